[rtl/lkvc_pkg.sv]
// ---------------------------------------------------------------------------
// lkvc_pkg - shared definitions for the LRU key-value cache
// Field widths, register reset value, request codes and the command bundle
// that the controller sends to the datapath.
// ---------------------------------------------------------------------------
package lkvc_pkg;

    // fixed widths of the channel fields and the capacity register
    localparam int FIELD_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // defaults for the top-level parameters
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // request action codes
    localparam logic ACT_SET = 1'b0;
    localparam logic ACT_GET = 1'b1;

    // controller to datapath commands, at most one per cycle
    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic do_match;   // compare keys, pick victim and free slot
        logic do_update;  // update ages, keys and values
        logic load_rsp;   // move the result into the output register
    } t_cmd;

endpackage

[rtl/lkvc_req_if.sv]
// ---------------------------------------------------------------------------
// lkvc_req_if - request channel of the LRU key-value cache
// Valid/ready handshake carrying action, key and value.
// ---------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               action;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] new_value;

    modport source (output valid, output action, output lookup_key,
                    output new_value, input ready);
    modport sink   (input valid, input action, input lookup_key,
                    input new_value, output ready);

endinterface

[rtl/lkvc_rsp_if.sv]
// ---------------------------------------------------------------------------
// lkvc_rsp_if - response channel of the LRU key-value cache
// Valid/ready handshake carrying hit, read value and eviction report.
// ---------------------------------------------------------------------------
interface lkvc_rsp_if import lkvc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_value,
                    output evicted, output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value,
                    input evicted, input evicted_key, output ready);

endinterface

[rtl/lkvc_ctrl.sv]
// ---------------------------------------------------------------------------
// lkvc_ctrl - request sequencer of the LRU key-value cache
// Steps each request through match, update and result hand-off, and owns
// the valid bit of the output register.
// ---------------------------------------------------------------------------
module lkvc_ctrl import lkvc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   rsp_free;

    // output register can take a new result this cycle
    assign rsp_free = !r_rsp_valid || i_rsp_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_MATCH;
                end
            end
            ST_MATCH: begin
                o_cmd.do_match = 1'b1;
                n_state        = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.do_update = 1'b1;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                if (rsp_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

[rtl/lkvc_dp.sv]
// ---------------------------------------------------------------------------
// lkvc_dp - datapath of the LRU key-value cache
// Key CAM with valid bits and recency ranks, value memory, capacity register,
// result staging and the output payload register.
// ---------------------------------------------------------------------------
module lkvc_dp import lkvc_pkg::*; #(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    input  logic               i_action,
    input  logic [FIELD_W-1:0] i_lookup_key,
    input  logic [FIELD_W-1:0] i_new_value,
    output logic               o_hit,
    output logic [FIELD_W-1:0] o_read_value,
    output logic               o_evicted,
    output logic [FIELD_W-1:0] o_evicted_key
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int AGE_W   = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEXT_W  = KEY_BITS + FIELD_W;
    localparam int VEXT_W  = VALUE_BITS + FIELD_W;

    // request capture
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_get;
    logic [KEXT_W-1:0]     in_key_ext;
    logic [VEXT_W-1:0]     in_val_ext;

    // slot state
    logic [KEY_BITS-1:0]   r_slot_key [ENTRIES];
    logic [AGE_W-1:0]      r_age      [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [OCC_W-1:0]      r_occ;
    logic [CAP_W-1:0]      r_cap;
    logic [VALUE_BITS-1:0] r_mem      [ENTRIES];
    logic [VALUE_BITS-1:0] r_rd_value;

    // match results
    logic [ENTRIES-1:0]    match_vec, victim_vec, free_vec;
    logic [ENTRIES-1:0]    r_match_vec, r_victim_vec, r_ins_vec;
    logic [IDX_W-1:0]      found_idx, victim_idx, free_idx;
    logic [IDX_W-1:0]      r_found_idx, r_ins_idx;
    logic                  r_hit, r_full;
    logic [OCC_W-1:0]      occ_m1;
    logic [CMP_W-1:0]      cap_ext, cap_eff, occ_ext;
    logic                  full;

    // update helpers
    logic [AGE_W-1:0]      found_age;
    logic [KEY_BITS-1:0]   victim_key;
    logic                  ins_en;

    // result staging and output register
    logic                  r_st_hit, r_st_evicted;
    logic [KEY_BITS-1:0]   r_st_evkey;
    logic [KEXT_W-1:0]     ev_key_ext;
    logic [VEXT_W-1:0]     rd_ext;
    logic                  r_out_hit, r_out_evicted;
    logic [FIELD_W-1:0]    r_out_value, r_out_evkey;

    // request capture, fields fitted to the stored widths
    assign in_key_ext = KEXT_W'(i_lookup_key);
    assign in_val_ext = VEXT_W'(i_new_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_key <= in_key_ext[KEY_BITS-1:0];
            r_val <= in_val_ext[VALUE_BITS-1:0];
            r_get <= (i_action == ACT_GET);
        end
    end

    // effective capacity, clamped to 1..ENTRIES
    assign cap_ext = CMP_W'(r_cap);
    assign occ_ext = CMP_W'(r_occ);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end
    assign full = (occ_ext >= cap_eff);

    // parallel key compare; the least recent valid slot has rank occupancy-1
    assign occ_m1   = r_occ - OCC_W'(1);
    assign free_vec = ~r_valid & (r_valid + ENTRIES'(1));
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = r_valid[i] && (r_slot_key[i] == r_key);
            victim_vec[i] = r_valid[i] && (r_age[i] == occ_m1[AGE_W-1:0]);
        end
    end

    // one-hot to index
    always_comb begin
        found_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i])  found_idx  = found_idx  | IDX_W'(i);
            if (victim_vec[i]) victim_idx = victim_idx | IDX_W'(i);
            if (free_vec[i])   free_idx   = free_idx   | IDX_W'(i);
        end
    end

    // match stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_match) begin
            r_match_vec  <= match_vec;
            r_victim_vec <= victim_vec;
            r_ins_vec    <= full ? victim_vec : free_vec;
            r_found_idx  <= found_idx;
            r_ins_idx    <= full ? victim_idx : free_idx;
            r_hit        <= |match_vec;
            r_full       <= full;
        end
    end

    // rank of the hit slot and key of the victim
    always_comb begin
        found_age  = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match_vec[i])  found_age  = found_age  | r_age[i];
            if (r_victim_vec[i]) victim_key = victim_key | r_slot_key[i];
        end
    end

    assign ins_en = i_cmd.do_update && !r_hit && !r_get;

    // valid bits, recency ranks, occupancy and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.do_update && r_hit) begin
                // touch: slots more recent than the hit one age by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_match_vec[i]) begin
                        r_age[i] <= '0;
                    end else if (r_valid[i] && (r_age[i] < found_age)) begin
                        r_age[i] <= r_age[i] + AGE_W'(1);
                    end
                end
            end else if (ins_en) begin
                // insert: every other valid slot ages, new entry is rank 0
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_ins_vec[i]) begin
                        r_age[i] <= '0;
                    end else if (r_valid[i]) begin
                        r_age[i] <= r_age[i] + AGE_W'(1);
                    end
                end
                r_valid <= r_valid | r_ins_vec;
                if (!r_full) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
            end
        end
    end

    // key CAM write
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (ins_en && r_ins_vec[i]) begin
                r_slot_key[i] <= r_key;
            end
        end
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            r_mem[r_ins_idx] <= r_val;
        end
        if (i_cmd.do_update) begin
            r_rd_value <= r_mem[r_found_idx];
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_update) begin
            r_st_hit     <= r_hit;
            r_st_evicted <= !r_hit && !r_get && r_full;
            r_st_evkey   <= (!r_hit && !r_get && r_full) ? victim_key : '0;
        end
    end

    // output payload register
    assign ev_key_ext = KEXT_W'(r_st_evkey);
    assign rd_ext     = VEXT_W'(r_rd_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_out_hit     <= r_st_hit;
            r_out_value   <= (r_st_hit && r_get) ? rd_ext[FIELD_W-1:0] : '0;
            r_out_evicted <= r_st_evicted;
            r_out_evkey   <= ev_key_ext[FIELD_W-1:0];
        end
    end

    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_value;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evkey;

endmodule

[rtl/lru_key_value_cache.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache - fully associative key-value cache, LRU replacement
// Set inserts a new key (evicting the least recent entry once capacity is
// reached) or touches a present one; get looks a key up and touches it.
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    action, lookup_key, new_value
//   o_rsp     out   valid / ready    hit, read_value, evicted, evicted_key
//   i_cfg_*   in    write enable     capacity (5 bits)
//
// From accept to the next accept each request steps through capture,
// key match, state update with value-memory read and result hand-off.
// The output register decouples the sides: a new request is accepted while
// a result waits; the hand-off step waits while that result is not taken.
// Synchronous reset empties the cache at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lkvc_req_if.sink         i_req,
    lkvc_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_cmd cmd;

    // request sequencer
    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // storage and result datapath
    lkvc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (i_req.action),
        .i_lookup_key  (i_req.lookup_key),
        .i_new_value   (i_req.new_value),
        .o_hit         (o_rsp.hit),
        .o_read_value  (o_rsp.read_value),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (o_rsp.evicted_key)
    );

    // at most one sequencer step per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_req, cmd.do_match, cmd.do_update, cmd.load_rsp}))
        else $error("more than one datapath command in a cycle");

    // an accepted request goes to key match next
    a_accept_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> cmd.do_match)
        else $error("accepted request not followed by key match");

    // a result never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_rsp |-> (!o_rsp.valid || o_rsp.ready))
        else $error("output register overwritten before hand-off");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.evicted))
        else $error("response reports both hit and eviction");

endmodule

[dv/lru_key_value_cache_test.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache_test - self-checking bench for the LRU key-value cache
// Drives set/get requests with random idling on both channels, predicts each
// response with a shadow copy of the slots and their recency ranks, and
// compares every response field against the oldest prediction. Phases step
// the capacity register through its extremes while the cache stays filled.
// ---------------------------------------------------------------------------
module lru_key_value_cache_test;
    import lkvc_pkg::*;

    localparam int SLOTS           = DEF_ENTRIES;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] lookup_key;
        logic [FIELD_W-1:0] new_value;
    } t_request;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] read_value;
        logic               evicted;
        logic [FIELD_W-1:0] evicted_key;
    } t_response;

    // Shadow of the cache contents plus the queue of predicted responses
    class cache_scoreboard;
        logic [FIELD_W-1:0] slot_key   [SLOTS];
        logic [FIELD_W-1:0] slot_value [SLOTS];
        logic               slot_live  [SLOTS];
        logic [3:0]         slot_rank  [SLOTS];
        logic [CAP_W-1:0]   fill_count;
        logic [CAP_W-1:0]   capacity;
        t_response          expected_responses [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_live[i]  = 1'b0;
                slot_rank[i]  = '0;
            end
            fill_count = '0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // every live slot drops one rank, ahead of a new entry taking rank 0
        function void age_live_slots();
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i]) slot_rank[i] = slot_rank[i] + 1'b1;
        endfunction

        function void install(int s, t_request r);
            age_live_slots();
            slot_key[s]   = r.lookup_key;
            slot_value[s] = r.new_value;
            slot_live[s]  = 1'b1;
            slot_rank[s]  = '0;
        endfunction

        // Response of one request; updates the shadow state
        function t_response predict_lookup(t_request r);
            t_response        rsp;
            int               found;
            int               victim;
            logic [3:0]       old_rank;
            logic [3:0]       oldest;
            logic [CAP_W-1:0] limit;

            rsp   = '0;
            found = -1;
            // out-of-range capacity clamps to 1..SLOTS
            limit = capacity;
            if (limit == 0) limit = CAP_W'(1);
            if (limit > SLOTS) limit = CAP_W'(SLOTS);

            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && slot_live[i] && slot_key[i] == r.lookup_key) found = i;

            // hit: touch the entry; only a get returns the value
            if (found >= 0) begin
                old_rank = slot_rank[found];
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && i != found && slot_rank[i] < old_rank)
                        slot_rank[i] = slot_rank[i] + 1'b1;
                slot_rank[found] = '0;
                rsp.hit = 1'b1;
                if (r.action == ACT_GET) rsp.read_value = slot_value[found];
                return rsp;
            end
            if (r.action == ACT_GET) return rsp;

            // full (or over capacity after a lowering): replace the least recent
            if (fill_count >= limit) begin
                victim = -1;
                oldest = '0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && (victim < 0 || slot_rank[i] > oldest)) begin
                        victim = i;
                        oldest = slot_rank[i];
                    end
                rsp.evicted     = 1'b1;
                rsp.evicted_key = slot_key[victim];
                slot_live[victim] = 1'b0;
                install(victim, r);
                return rsp;
            end

            // otherwise the first free slot
            for (int i = 0; i < SLOTS; i++)
                if (!slot_live[i]) begin
                    install(i, r);
                    fill_count = fill_count + 1'b1;
                    break;
                end
            return rsp;
        endfunction

        function void note_request(t_request r);
            expected_responses.push_back(predict_lookup(r));
        endfunction

        task report_mismatch(string field, logic [FIELD_W-1:0] want,
                             logic [FIELD_W-1:0] got);
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
            mismatches++;
        endtask

        task check_response(t_response got);
            t_response want;
            if (expected_responses.size() == 0) begin
                report_mismatch("unexpected response", '0, got.evicted_key);
                return;
            end
            want = expected_responses.pop_front();
            if (got.hit !== want.hit)
                report_mismatch("hit", want.hit, got.hit);
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", want.read_value, got.read_value);
            if (got.evicted !== want.evicted)
                report_mismatch("evicted", want.evicted, got.evicted);
            if (got.evicted_key !== want.evicted_key)
                report_mismatch("evicted_key", want.evicted_key, got.evicted_key);
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lkvc_req_if req_bus ();
    lkvc_rsp_if rsp_bus ();

    lru_key_value_cache DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    cache_scoreboard  sb = new();
    bit               idle_req;
    bit               idle_rsp;
    bit               long_hold_req;
    bit               hold_done;
    int               rsp_pause;
    int               cycle_count;
    logic [FIELD_W-1:0] key_pool [32];
    int               pool_size;

    // 8-unit clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_request make_request(logic act, logic [FIELD_W-1:0] key,
                                              logic [FIELD_W-1:0] val);
        t_request r;
        r.action     = act;
        r.lookup_key = key;
        r.new_value  = val;
        return r;
    endfunction

    // pool a bit larger than the capacity, so gets both hit and miss
    function automatic void build_key_pool(int size);
        int r;
        pool_size = size;
        for (int i = 0; i < size; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0)      key_pool[i] = '0;
            else if (r == 1) key_pool[i] = '1;
            else             key_pool[i] = $urandom;
        end
    endfunction

    function automatic t_request random_request();
        logic [FIELD_W-1:0] key;
        logic               act;
        act = ($urandom_range(0, 1) == 1) ? ACT_GET : ACT_SET;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else                           key = key_pool[$urandom_range(0, pool_size - 1)];
        return make_request(act, key, $urandom);
    endfunction

    // Offer one request; returns at the edge where it is taken
    task automatic send_request(t_request r);
        int gap;
        gap = idle_req ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid      = 1'b1;
        req_bus.action     = r.action;
        req_bus.lookup_key = r.lookup_key;
        req_bus.new_value  = r.new_value;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_request(r);
    endtask

    // Stop offering and let every outstanding response come back
    task automatic drain_responses();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic change_capacity(logic [CAP_W-1:0] cap);
        drain_responses();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        sb.set_capacity(cap);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Response side: ready with random pauses, plus the long hold on request
    initial begin
        rsp_bus.ready = 1'b0;
        rsp_pause     = 0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done     = 1'b1;
                rsp_bus.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (rsp_pause > 0) begin
                rsp_bus.ready = 1'b0;
                rsp_pause--;
            end else begin
                rsp_bus.ready = 1'b1;
                if (idle_rsp) rsp_pause = pick_gap();
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_response({rsp_bus.hit, rsp_bus.read_value,
                               rsp_bus.evicted, rsp_bus.evicted_key});
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial begin
        logic [CAP_W-1:0] cap_plan [8];
        logic [CAP_W-1:0] cap;
        int               eff_cap;

        cap_plan = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd2, 5'd15, 5'd20};
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_bus.valid      = 1'b0;
        req_bus.action     = ACT_SET;
        req_bus.lookup_key = '0;
        req_bus.new_value  = '0;
        idle_req           = 1'b1;
        idle_rsp           = 1'b1;
        long_hold_req      = 1'b0;
        pool_size          = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // get on an empty cache, extreme keys and values, set hit keeps value
        send_request(make_request(ACT_GET, 32'h0000_0000, 32'hDEAD_BEEF));
        send_request(make_request(ACT_SET, 32'h0000_0000, 32'hFFFF_FFFF));
        send_request(make_request(ACT_SET, 32'hFFFF_FFFF, 32'h0000_0000));
        send_request(make_request(ACT_GET, 32'h0000_0000, 32'h0));
        send_request(make_request(ACT_GET, 32'hFFFF_FFFF, 32'h0));
        send_request(make_request(ACT_SET, 32'h0000_0000, 32'h1234_5678));
        send_request(make_request(ACT_GET, 32'h0000_0000, 32'h0));
        send_request(make_request(ACT_GET, 32'h0000_0005, 32'h0));
        // at capacity: new key evicts the least recent
        change_capacity(5'd2);
        send_request(make_request(ACT_SET, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        send_request(make_request(ACT_GET, 32'hFFFF_FFFF, 32'h0));
        // capacity below occupancy: entries stay, each new key evicts one
        change_capacity(5'd1);
        send_request(make_request(ACT_SET, 32'h5A5A_5A5A, 32'hA5A5_A5A5));
        send_request(make_request(ACT_GET, 32'hA5A5_A5A5, 32'h0));
        send_request(make_request(ACT_GET, 32'h5A5A_5A5A, 32'h0));
        // zero capacity behaves as one
        change_capacity(5'd0);
        send_request(make_request(ACT_SET, 32'h0000_0003, 32'h8000_0001));
        send_request(make_request(ACT_SET, 32'h0000_0004, 32'h7FFF_FFFE));
        send_request(make_request(ACT_GET, 32'h0000_0003, 32'h0));
        send_request(make_request(ACT_GET, 32'h0000_0004, 32'h0));
        // above the slot count clamps to all slots
        change_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_request(make_request(ACT_SET, 32'h100 + i, 32'hC000_0000 | i));

        // Random phases over a range of capacities
        for (int ph = 0; ph < PHASES; ph++) begin
            cap = (ph < 8) ? cap_plan[ph] : CAP_W'($urandom_range(0, 31));
            change_capacity(cap);
            eff_cap = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : int'(cap));
            build_key_pool(eff_cap + $urandom_range(1, 8));
            idle_req = (ph % 4 != 1);
            idle_rsp = (ph % 4 != 2);
            // back-pressure: response side holds off while requests keep coming
            if (ph == 3) begin
                idle_req      = 1'b0;
                long_hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end

        drain_responses();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
